// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the sorter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed");

`endif

// ----- rtl/core/ist_pkg.sv -----
// Package for the insertion sorter: sizes, transaction payload types and
// the link struct passed between neighbouring cells. No dependencies.
package ist_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] t_value;
    typedef logic [CNT_W-1:0]   t_count;

    typedef struct packed {
        t_value item_value;
        logic   final_item;
    } t_in_item;

    typedef struct packed {
        t_value sorted_value;
        logic   run_end;
        logic   dropped;
    } t_out_item;

    // what a cell shows its neighbours
    typedef struct packed {
        logic   valid;
        logic   gt;
        t_value value;
    } t_cell_link;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

    // empty cell 0 must take the new value: its left side acts as occupied
    localparam t_cell_link LEFT_EDGE  = '{valid: 1'b1, gt: 1'b0, value: '0};
    localparam t_cell_link RIGHT_EDGE = '{valid: 1'b0, gt: 1'b0, value: '0};

endpackage

// ----- rtl/core/ist_cell.sv -----
// One cell of the insertion chain: holds a single value and its valid bit.
// Depends on ist_pkg.
module ist_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ist_pkg::t_cell_ctl  i_ctl,
    input  ist_pkg::t_value     i_item,
    input  ist_pkg::t_cell_link i_left,
    input  ist_pkg::t_cell_link i_right,
    output ist_pkg::t_cell_link o_link
);

    logic            r_valid;
    ist_pkg::t_value r_val;
    logic            n_valid;
    ist_pkg::t_value n_val;
    logic            w_gt;

    assign w_gt = r_valid && (r_val > i_item);

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        if (i_ctl.shift) begin
            n_valid = i_right.valid;
            n_val   = i_right.value;
        end else if (i_ctl.ins) begin
            if (i_left.gt) begin
                n_valid = 1'b1;
                n_val   = i_left.value;
            end else if (w_gt || (!r_valid && i_left.valid)) begin
                n_valid = 1'b1;
                n_val   = i_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link = '{valid: r_valid, gt: w_gt, value: r_val};

endmodule

// ----- rtl/core/insertion_sort_integers.sv -----
// Insertion sorter top level: chain of ist_cell instances plus unload control.
// Depends on ist_pkg, ist_cell and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one signed
// element per transaction; final_item closes the batch. While loading, one
// element is accepted every cycle: each cell compares itself with the new
// value and the chain shifts right by one from the insertion point.
// After the final transaction the chain unloads from cell 0 into the output
// register, one result per cycle unless stalled, ascending, run_end on the last
// and dropped on all if more than CAPACITY elements came in (extras are discarded).
// The first result reaches the output register after the final transaction
// has set r_drain; o_in_stall is high while the held elements unload.
// The next batch may start while the last result still waits.
// If i_out_stall is high while a result is held, the output register holds and the unload pauses.
// Synchronous active-low reset empties the chain and drops any batch.
`include "assert_macros.svh"

module insertion_sort_integers (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ist_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ist_pkg::t_out_item o_out_data
);

    ist_pkg::t_cell_link w_link [ist_pkg::CAPACITY];
    ist_pkg::t_cell_ctl  w_ctl;

    logic               r_drain;
    logic               r_ovf;
    ist_pkg::t_count    r_count;
    logic               r_out_valid;
    ist_pkg::t_out_item r_out_data;

    logic w_in_acc;
    logic w_full;
    logic w_load;
    logic w_last;

    assign w_in_acc  = i_in_valid && !r_drain;
    assign w_full    = r_count == ist_pkg::CNT_W'(ist_pkg::CAPACITY);
    assign w_load    = r_drain && (!r_out_valid || !i_out_stall);
    assign w_last    = r_count == ist_pkg::CNT_W'(1);
    assign w_ctl.ins   = w_in_acc && !w_full;
    assign w_ctl.shift = w_load;

    for (genvar g = 0; g < ist_pkg::CAPACITY; g++) begin : g_cell
        ist_pkg::t_cell_link w_left;
        ist_pkg::t_cell_link w_right;
        if (g == 0) begin : g_first
            assign w_left = ist_pkg::LEFT_EDGE;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end
        if (g == ist_pkg::CAPACITY - 1) begin : g_last
            assign w_right = ist_pkg::RIGHT_EDGE;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end
        ist_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_item  (i_in_data.item_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain     <= 1'b0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + ist_pkg::CNT_W'(1);
                end
                if (i_in_data.final_item) begin
                    r_drain <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_count     <= r_count - ist_pkg::CNT_W'(1);
                if (w_last) begin
                    r_drain <= 1'b0;
                    r_ovf   <= 1'b0;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= '{sorted_value: w_link[0].value, run_end: w_last, dropped: r_ovf};
        end
    end

    assign o_in_stall  = r_drain;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= ist_pkg::CNT_W'(ist_pkg::CAPACITY))
    `ASSERT_IMPLIES(a_full_tail, i_clk, i_rst_n, 1'b1,
        w_link[ist_pkg::CAPACITY-1].valid == w_full)
    `ASSERT_IMPLIES(a_load_head, i_clk, i_rst_n, w_load, w_link[0].valid)
    `ASSERT_NEXT(a_unload_end, i_clk, i_rst_n, w_load && w_last,
        !r_drain && !r_ovf && !w_link[0].valid)

endmodule
